[rtl/amge_pkg.sv]
package amge_pkg;

	localparam int VERTEX_W = 5;
	localparam int COUNT_W  = 6;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// vertex_count is the only register; paddr[2] selects the word
	localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 6'd32;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_COMMON = 2'd1,
		OP_WALK   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALID   = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_A   = 2'd0,
		SEL_B   = 2'd1,
		SEL_TOP = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_A    = 2'd1,
		WR_B    = 2'd2
	} wr_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD_WR_A,
		S_ADD_RD_B,
		S_ADD_WR_B,
		S_CN_RD_B,
		S_CN_AND,
		S_CN_SCAN,
		S_W_INIT,
		S_W_FETCH,
		S_W_ROW,
		S_W_POP
	} state_t;

	typedef struct packed {
		logic    load_in;
		logic    adj_rd;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    cap_row_a;
		logic    load_common;
		logic    scan_step;
		logic    emit_err;
		logic    emit_empty;
		logic    walk_init;
		logic    walk_step;
		logic    walk_pop_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic invalid;
		logic common_zero;
		logic scan_last;
		logic found;
		logic stack_last;
	} stat_t;

endpackage

[rtl/amge_ram.sv]
module amge_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/amge_ctrl.sv]
module amge_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  amge_pkg::stat_t stat,
	output amge_pkg::cmd_t  cmd
);

	amge_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amge_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != amge_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			amge_pkg::S_IDLE: begin
				if (start) state_d = amge_pkg::S_DISPATCH;
			end
			amge_pkg::S_DISPATCH: begin
				if (stat.op == amge_pkg::OP_NOP || stat.invalid) begin
					state_d = amge_pkg::S_IDLE;
				end else begin
					case (stat.op)
						amge_pkg::OP_ADD:    state_d = amge_pkg::S_ADD_WR_A;
						amge_pkg::OP_COMMON: state_d = amge_pkg::S_CN_RD_B;
						amge_pkg::OP_WALK:   state_d = amge_pkg::S_W_INIT;
						default:             state_d = amge_pkg::S_IDLE;
					endcase
				end
			end
			amge_pkg::S_ADD_WR_A: state_d = amge_pkg::S_ADD_RD_B;
			amge_pkg::S_ADD_RD_B: state_d = amge_pkg::S_ADD_WR_B;
			amge_pkg::S_ADD_WR_B: state_d = amge_pkg::S_IDLE;
			amge_pkg::S_CN_RD_B:  state_d = amge_pkg::S_CN_AND;
			amge_pkg::S_CN_AND:   state_d = amge_pkg::S_CN_SCAN;
			amge_pkg::S_CN_SCAN: begin
				if (stat.common_zero || stat.scan_last) state_d = amge_pkg::S_IDLE;
			end
			amge_pkg::S_W_INIT:  state_d = amge_pkg::S_W_FETCH;
			amge_pkg::S_W_FETCH: state_d = amge_pkg::S_W_ROW;
			amge_pkg::S_W_ROW: begin
				if (stat.found) begin
					state_d = amge_pkg::S_W_FETCH;
				end else if (stat.stack_last) begin
					state_d = amge_pkg::S_IDLE;
				end else begin
					state_d = amge_pkg::S_W_POP;
				end
			end
			amge_pkg::S_W_POP: state_d = amge_pkg::S_W_FETCH;
			default:           state_d = amge_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			amge_pkg::S_IDLE: begin
				cmd.load_in = start;
			end
			amge_pkg::S_DISPATCH: begin
				if (stat.op != amge_pkg::OP_NOP) begin
					if (stat.invalid) begin
						cmd.emit_err = 1'b1;
					end else if (stat.op != amge_pkg::OP_WALK) begin
						cmd.adj_rd = 1'b1;
						cmd.rd_sel = amge_pkg::SEL_A;
					end
				end
			end
			amge_pkg::S_ADD_WR_A: cmd.wr_sel = amge_pkg::WR_A;
			amge_pkg::S_ADD_RD_B: begin
				cmd.adj_rd = 1'b1;
				cmd.rd_sel = amge_pkg::SEL_B;
			end
			amge_pkg::S_ADD_WR_B: cmd.wr_sel = amge_pkg::WR_B;
			amge_pkg::S_CN_RD_B: begin
				cmd.cap_row_a = 1'b1;
				cmd.adj_rd    = 1'b1;
				cmd.rd_sel    = amge_pkg::SEL_B;
			end
			amge_pkg::S_CN_AND: cmd.load_common = 1'b1;
			amge_pkg::S_CN_SCAN: begin
				if (stat.common_zero) begin
					cmd.emit_empty = 1'b1;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			amge_pkg::S_W_INIT: cmd.walk_init = 1'b1;
			amge_pkg::S_W_FETCH: begin
				cmd.adj_rd = 1'b1;
				cmd.rd_sel = amge_pkg::SEL_TOP;
			end
			amge_pkg::S_W_ROW: cmd.walk_step = 1'b1;
			amge_pkg::S_W_POP: cmd.walk_pop_load = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/amge_datapath.sv]
module amge_datapath #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  amge_pkg::cmd_t                  cmd,
	output amge_pkg::stat_t                 stat,
	input  logic [1:0]                      op,
	input  logic [amge_pkg::VERTEX_W-1:0]   first_vertex,
	input  logic [amge_pkg::VERTEX_W-1:0]   second_vertex,
	input  logic [amge_pkg::COUNT_W-1:0]    vertex_count,
	output logic                            result_valid,
	output logic [amge_pkg::VERTEX_W-1:0]   vertex,
	output logic [amge_pkg::STATUS_W-1:0]   status,
	output logic                            last
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 1);
	localparam int NW = 7;

	function automatic logic [MAX_VERTICES-1:0] lowest_bit(input logic [MAX_VERTICES-1:0] x);
		return x & (~x + 1'b1);
	endfunction

	function automatic logic [VW-1:0] onehot_index(input logic [MAX_VERTICES-1:0] x);
		logic [VW-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (x[i]) idx = idx | VW'(i);
		end
		return idx;
	endfunction

	amge_pkg::op_t                 op_q;
	logic [amge_pkg::VERTEX_W-1:0] a_q, b_q;
	logic [VW-1:0]                 a_idx, b_idx;
	logic [NW-1:0]                 n_act;
	logic [MAX_VERTICES-1:0]       mask, bit_a, bit_b;
	logic [VW-1:0]                 top_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= amge_pkg::op_t'(op);
			a_q  <= first_vertex;
			b_q  <= second_vertex;
		end
	end

	assign a_idx = VW'(a_q);
	assign b_idx = VW'(b_q);

	// effective count: min(vertex_count, MAX_VERTICES)
	always_comb begin
		if (NW'(vertex_count) < NW'(MAX_VERTICES)) begin
			n_act = NW'(vertex_count);
		end else begin
			n_act = NW'(MAX_VERTICES);
		end
		for (int i = 0; i < MAX_VERTICES; i++) begin
			mask[i]  = (NW'(i) < n_act);
			bit_a[i] = (a_idx == VW'(i));
			bit_b[i] = (b_idx == VW'(i));
		end
	end

	// adjacency rows: RAM plus one valid flag per row, unwritten rows read as zero
	logic                    adj_wr_en, adj_rd_en, rd_valid_s1;
	logic [VW-1:0]           adj_wr_addr, adj_rd_addr;
	logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data, adj_row;
	logic [MAX_VERTICES-1:0] row_valid_q;

	always_comb begin
		adj_wr_en   = (cmd.wr_sel != amge_pkg::WR_NONE);
		adj_wr_addr = (cmd.wr_sel == amge_pkg::WR_B) ? b_idx : a_idx;
		adj_wr_data = adj_row | ((cmd.wr_sel == amge_pkg::WR_B) ? bit_a : bit_b);
		adj_rd_en   = cmd.adj_rd;
		case (cmd.rd_sel)
			amge_pkg::SEL_A:   adj_rd_addr = a_idx;
			amge_pkg::SEL_B:   adj_rd_addr = b_idx;
			amge_pkg::SEL_TOP: adj_rd_addr = top_q;
			default:           adj_rd_addr = a_idx;
		endcase
	end

	assign adj_row = rd_valid_s1 ? adj_rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (adj_wr_en) row_valid_q[adj_wr_addr] <= 1'b1;
			if (adj_rd_en) rd_valid_s1 <= row_valid_q[adj_rd_addr];
		end
	end

	amge_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_adj_ram (
		.clk     (clk),
		.wr_en   (adj_wr_en),
		.wr_addr (adj_wr_addr),
		.wr_data (adj_wr_data),
		.rd_en   (adj_rd_en),
		.rd_addr (adj_rd_addr),
		.rd_data (adj_rd_data)
	);

	// common neighbours
	logic [MAX_VERTICES-1:0] row_a_q, common_q, common_low, common_rem;
	logic [VW-1:0]           common_idx;

	assign common_low = lowest_bit(common_q);
	assign common_rem = common_q & ~common_low;
	assign common_idx = onehot_index(common_low);

	always_ff @(posedge clk) begin
		if (cmd.cap_row_a) row_a_q <= adj_row;
		if (cmd.load_common) begin
			common_q <= row_a_q & adj_row & mask;
		end else if (cmd.scan_step) begin
			common_q <= common_rem;
		end
	end

	// depth-first walk
	logic [MAX_VERTICES-1:0] visited_q, cand, cand_low;
	logic [DW-1:0]           depth_q;
	logic [VW-1:0]           pend_q, u_idx;
	logic                    found;
	logic                    stk_wr_en, stk_rd_en;
	logic [VW-1:0]           stk_wr_addr, stk_wr_data, stk_rd_addr, stk_rd_data;

	assign cand     = adj_row & mask & ~visited_q;
	assign cand_low = lowest_bit(cand);
	assign u_idx    = onehot_index(cand_low);
	assign found    = (|cand) && (depth_q < DW'(MAX_VERTICES));

	assign stk_wr_en   = cmd.walk_init || (cmd.walk_step && found);
	assign stk_wr_addr = cmd.walk_init ? '0 : depth_q[VW-1:0];
	assign stk_wr_data = cmd.walk_init ? a_idx : u_idx;
	assign stk_rd_en   = cmd.walk_step && !found && (depth_q != DW'(1));
	assign stk_rd_addr = VW'(depth_q - DW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q   <= '0;
		end else if (cmd.walk_init) begin
			visited_q <= bit_a;
			depth_q   <= DW'(1);
		end else if (cmd.walk_step) begin
			if (found) begin
				visited_q <= visited_q | cand_low;
				depth_q   <= depth_q + DW'(1);
			end else begin
				depth_q   <= depth_q - DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			top_q  <= a_idx;
			pend_q <= a_idx;
		end else if (cmd.walk_step && found) begin
			top_q  <= u_idx;
			pend_q <= u_idx;
		end else if (cmd.walk_pop_load) begin
			top_q  <= stk_rd_data;
		end
	end

	amge_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_VERTICES)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (stk_wr_data),
		.rd_en   (stk_rd_en),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

	// result word register
	logic                          emit;
	logic [amge_pkg::VERTEX_W-1:0] emit_vertex;
	amge_pkg::status_t             emit_status;
	logic                          emit_last;

	always_comb begin
		emit        = 1'b0;
		emit_vertex = '0;
		emit_status = amge_pkg::ST_VALID;
		emit_last   = 1'b1;
		if (cmd.emit_err) begin
			emit        = 1'b1;
			emit_status = amge_pkg::ST_INVALID;
		end else if (cmd.emit_empty) begin
			emit        = 1'b1;
			emit_status = amge_pkg::ST_EMPTY;
		end else if (cmd.scan_step) begin
			emit        = 1'b1;
			emit_vertex = amge_pkg::VERTEX_W'(common_idx);
			emit_last   = (common_rem == '0);
		end else if (cmd.walk_step) begin
			// the held vertex goes out once we know whether another follows
			emit        = found || (depth_q == DW'(1));
			emit_vertex = amge_pkg::VERTEX_W'(pend_q);
			emit_last   = !found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			vertex <= emit_vertex;
			status <= emit_status;
			last   <= emit_last;
		end
	end

	always_comb begin
		stat.op          = op_q;
		stat.invalid     = !(NW'(a_q) < n_act)
		                   || ((op_q != amge_pkg::OP_WALK) && !(NW'(b_q) < n_act));
		stat.common_zero = (common_q == '0);
		stat.scan_last   = (common_rem == '0);
		stat.found       = found;
		stat.stack_last  = (depth_q == DW'(1));
	end

endmodule

[rtl/adjacency_matrix_graph_engine_core.sv]
// Undirected graph engine over an adjacency bit matrix.
//
// Command channel: drive op, first_vertex, second_vertex with start high; the
// word is taken at the rising edge where start is high and busy is low. busy
// drops as the last result word is registered; that word is on the ports in
// the first idle cycle, so the next command can be taken at the edge ending it.
// Result channel: each word (vertex, status, last) is present for exactly one
// cycle with result_valid high; the receiver cannot stall, so results go out
// as soon as the sequencer produces them. last marks the final word.
// Sequence from accept: add edge writes row a, reads row b, then writes row b;
// no result. Common neighbours reads both rows and ANDs them, then one word per
// cycle. The depth-first walk reads the row of the stack top (S_W_FETCH) and
// pushes a neighbour (S_W_ROW); on a backtrack it also loads the new top from
// the stack RAM (S_W_POP) before the next fetch.
// An invalid vertex gives one invalid word at dispatch; an unused op gives none.
// Config: APB, vertex_count at byte address 0; write only while busy is low.
// Reset: graph empty (per-row valid flags clear at once), vertex_count 32,
// no clearing pass needed.
module adjacency_matrix_graph_engine_core #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            op,
	input  logic [amge_pkg::VERTEX_W-1:0]         first_vertex,
	input  logic [amge_pkg::VERTEX_W-1:0]         second_vertex,
	// results
	output logic                                  result_valid,
	output logic [amge_pkg::VERTEX_W-1:0]         vertex,
	output logic [amge_pkg::STATUS_W-1:0]         status,
	output logic                                  last,
	// config
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [amge_pkg::ADDR_W-1:0]           paddr,
	input  logic [amge_pkg::DATA_W-1:0]           pwdata,
	output logic [amge_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);

	amge_pkg::cmd_t  cmd;
	amge_pkg::stat_t stat;

	// vertex_count register
	logic [amge_pkg::COUNT_W-1:0] vertex_count_q;
	logic                         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == amge_pkg::REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= amge_pkg::VERTEX_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			vertex_count_q <= pwdata[amge_pkg::COUNT_W-1:0];
		end
	end

	// reads of any other word return zero
	assign prdata = reg_sel ? amge_pkg::DATA_W'(vertex_count_q) : '0;

	// sequencer
	amge_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// matrix, stack, scan logic and result word register
	amge_datapath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.op            (op),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.vertex_count  (vertex_count_q),
		.result_valid  (result_valid),
		.vertex        (vertex),
		.status        (status),
		.last          (last)
	);

endmodule

[test/adjacency_matrix_graph_engine_core_tb.sv]
module adjacency_matrix_graph_engine_core_tb;

	localparam int NV          = 32;
	localparam int CYCLE_LIMIT = 400000;
	// vertex_count is word 0 of the register map
	localparam logic [amge_pkg::ADDR_W-1:0] COUNT_ADDR = {amge_pkg::REG_VERTEX_COUNT, 2'b00};

	// one command word and one result word
	typedef struct packed {
		amge_pkg::op_t                 code;
		logic [amge_pkg::VERTEX_W-1:0] a;
		logic [amge_pkg::VERTEX_W-1:0] b;
	} graph_cmd_t;

	typedef struct packed {
		logic [amge_pkg::VERTEX_W-1:0] vtx;
		amge_pkg::status_t             st;
		logic                          lst;
	} graph_word_t;

	// ------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------
	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          start         = 1'b0;
	logic [1:0]                    op            = 2'd0;
	logic [amge_pkg::VERTEX_W-1:0] first_vertex  = '0;
	logic [amge_pkg::VERTEX_W-1:0] second_vertex = '0;
	logic                          psel          = 1'b0;
	logic                          penable       = 1'b0;
	logic                          pwrite        = 1'b0;
	logic [amge_pkg::ADDR_W-1:0]   paddr         = '0;
	logic [amge_pkg::DATA_W-1:0]   pwdata        = '0;
	logic                          busy;
	logic                          result_valid;
	logic [amge_pkg::VERTEX_W-1:0] vertex;
	logic [amge_pkg::STATUS_W-1:0] status;
	logic                          last;
	logic [amge_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	always #5 clk = ~clk;

	adjacency_matrix_graph_engine_core uut (.*);

	// ------------------------------------------------------------------
	// shadow of the graph engine: matrix, active count, pending answers
	// ------------------------------------------------------------------
	logic [NV-1:0]                shadow_rows [NV] = '{default: '0};
	logic [amge_pkg::COUNT_W-1:0] shadow_count     = amge_pkg::VERTEX_COUNT_RESET;
	graph_word_t                  answer_q[$];
	graph_cmd_t                   cmd_q[$];
	int                           fail_count  = 0;
	int                           cycle_count = 0;

	function automatic void push_word(logic [amge_pkg::VERTEX_W-1:0] v,
			amge_pkg::status_t s, logic l);
		graph_word_t w;
		w.vtx = v;
		w.st  = s;
		w.lst = l;
		answer_q = {answer_q, w};
	endfunction

	// Apply one command to the shadow graph and queue the words it should produce.
	function automatic void predict_graph_op(amge_pkg::op_t code,
			logic [amge_pkg::VERTEX_W-1:0] a, logic [amge_pkg::VERTEX_W-1:0] b);
		int unsigned                   n;
		logic [NV-1:0]                 mask;
		logic [NV-1:0]                 common;
		logic [NV-1:0]                 cand;
		logic [NV-1:0]                 seen;
		int unsigned                   stk [NV];
		logic [amge_pkg::VERTEX_W-1:0] visit [NV];
		int unsigned                   depth;
		int unsigned                   top;
		int unsigned                   u;
		int unsigned                   k;
		int                            i;
		bit                            found;
		n = (shadow_count < NV) ? shadow_count : NV;
		for (i = 0; i < NV; i++)
			mask[i] = (i < n);
		if (code == amge_pkg::OP_NOP)
			return;
		// walk looks at the start vertex only
		if (a >= n || (code != amge_pkg::OP_WALK && b >= n)) begin
			push_word('0, amge_pkg::ST_INVALID, 1'b1);
			return;
		end
		case (code)
			amge_pkg::OP_ADD: begin
				shadow_rows[a][b] = 1'b1;
				shadow_rows[b][a] = 1'b1;
			end
			amge_pkg::OP_COMMON: begin
				common = shadow_rows[a] & shadow_rows[b] & mask;
				if (common == '0) begin
					push_word('0, amge_pkg::ST_EMPTY, 1'b1);
				end else begin
					for (i = 0; i < NV; i++) begin
						if (common[i]) begin
							common[i] = 1'b0;
							push_word(amge_pkg::VERTEX_W'(i), amge_pkg::ST_VALID,
								common == '0);
						end
					end
				end
			end
			default: begin
				// depth-first: lowest unvisited active neighbor of the stack top
				seen     = '0;
				seen[a]  = 1'b1;
				stk[0]   = a;
				depth    = 1;
				visit[0] = a;
				k        = 1;
				while (depth > 0) begin
					top   = stk[depth-1];
					cand  = shadow_rows[top] & mask & ~seen;
					found = 1'b0;
					u     = 0;
					for (i = 0; i < NV && !found; i++) begin
						if (cand[i]) begin
							found = 1'b1;
							u     = i;
						end
					end
					if (found && depth < NV) begin
						seen[u]    = 1'b1;
						stk[depth] = u;
						depth++;
						if (k < NV) begin
							visit[k] = amge_pkg::VERTEX_W'(u);
							k++;
						end
					end else begin
						depth--;
					end
				end
				for (i = 0; i < k; i++)
					push_word(visit[i], amge_pkg::ST_VALID, i == k - 1);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void queue_cmd(amge_pkg::op_t code, int a, int b);
		graph_cmd_t c;
		c.code = code;
		c.a    = amge_pkg::VERTEX_W'(a);
		c.b    = amge_pkg::VERTEX_W'(b);
		cmd_q  = {cmd_q, c};
	endfunction

	// mostly in range, some out of range to hit the reject path
	function automatic logic [amge_pkg::VERTEX_W-1:0] pick_vertex(int unsigned n);
		if (n == 0 || $urandom_range(0, 99) < 12)
			return amge_pkg::VERTEX_W'($urandom_range(0, NV - 1));
		return amge_pkg::VERTEX_W'($urandom_range(0, n - 1));
	endfunction

	// edge adds lead so the graph fills up and walks get long
	function automatic graph_cmd_t random_cmd(int unsigned n);
		graph_cmd_t  c;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			c.code = amge_pkg::OP_ADD;
		else if (r < 65)
			c.code = amge_pkg::OP_COMMON;
		else if (r < 93)
			c.code = amge_pkg::OP_WALK;
		else
			c.code = amge_pkg::OP_NOP;
		c.a = pick_vertex(n);
		c.b = pick_vertex(n);
		return c;
	endfunction

	// Wait for the command queue to drain and the engine to go idle, give late
	// words a bounded window, then flag anything still outstanding.
	task automatic settle();
		int          n;
		graph_word_t w;
		do @(negedge clk); while (cmd_q.size() != 0 || start || busy);
		for (n = 0; n < 64 && answer_q.size() != 0; n++)
			@(negedge clk);
		// add edge gives no word; cover its write latency
		repeat (10) @(negedge clk);
		if (answer_q.size() != 0) begin
			w = answer_q[0];
			$display("%0t: %0d expected words never came, first: vertex %0d status %0d last %0d",
				$time, answer_q.size(), w.vtx, w.st, w.lst);
			fail_count++;
			answer_q.delete();
		end
	endtask

	// APB transfer: setup cycle, then access cycle; pready is tied high
	task automatic apb_access(bit wr, logic [amge_pkg::COUNT_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= COUNT_ADDR;
		pwdata  <= amge_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// register change only while idle; read back right after
	task automatic set_vertex_count(logic [amge_pkg::COUNT_W-1:0] value);
		settle();
		apb_access(1'b1, value);
		apb_access(1'b0, '0);
	endtask

	// ------------------------------------------------------------------
	// driver: pops commands, holds start until accepted, random gaps
	// ------------------------------------------------------------------
	int unsigned hold_off = 0;
	bit          burst    = 1'b0;

	always @(posedge clk) begin
		graph_cmd_t  nxt;
		int unsigned gap;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !busy) begin
			// word taken at this edge; pick the gap before the next one
			if ($urandom_range(0, 9) == 0)
				burst = ~burst;
			gap = burst ? 0 : $urandom_range(0, 19);
			if (gap == 0 && cmd_q.size() != 0) begin
				nxt = cmd_q.pop_front();
				op            <= nxt.code;
				first_vertex  <= nxt.a;
				second_vertex <= nxt.b;
			end else begin
				start    <= 1'b0;
				hold_off <= gap;
			end
		end else if (!start) begin
			if (hold_off != 0) begin
				hold_off <= hold_off - 1;
			end else if (cmd_q.size() != 0) begin
				nxt = cmd_q.pop_front();
				op            <= nxt.code;
				first_vertex  <= nxt.a;
				second_vertex <= nxt.b;
				start         <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: compare result words, predict on accept, track the register
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		graph_word_t want;
		if (arst_n) begin
			// results first: a new command may be taken on the last word's edge
			if (result_valid) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected word vertex %0d status %0d last %0d",
						$time, vertex, status, last);
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					if (vertex !== want.vtx) begin
						$display("%0t: vertex mismatch exp %0d got %0d", $time, want.vtx, vertex);
						fail_count++;
					end
					if (status !== want.st) begin
						$display("%0t: status mismatch exp %0d got %0d", $time, want.st, status);
						fail_count++;
					end
					if (last !== want.lst) begin
						$display("%0t: last mismatch exp %0d got %0d", $time, want.lst, last);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				predict_graph_op(amge_pkg::op_t'(op), first_vertex, second_vertex);
			if (psel && penable && pready) begin
				if (pwrite) begin
					shadow_count = pwdata[amge_pkg::COUNT_W-1:0];
				end else if (prdata !== amge_pkg::DATA_W'(shadow_count)) begin
					$display("%0t: vertex_count readback exp %0d got %0d",
						$time, shadow_count, prdata);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [amge_pkg::COUNT_W-1:0] counts [5];
		int unsigned                  n;
		int                           p;
		int                           j;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		apb_access(1'b0, '0);   // reset value of vertex_count

		// full count: empty graph, then a small graph with a self loop
		queue_cmd(amge_pkg::OP_COMMON, 0, 31);    // nothing adjacent yet: empty answer
		queue_cmd(amge_pkg::OP_WALK, 31, 0);      // lone vertex walk
		queue_cmd(amge_pkg::OP_ADD, 0, 31);
		queue_cmd(amge_pkg::OP_ADD, 31, 0);       // duplicate edge
		queue_cmd(amge_pkg::OP_ADD, 5, 5);        // self loop
		queue_cmd(amge_pkg::OP_ADD, 0, 5);
		queue_cmd(amge_pkg::OP_ADD, 31, 5);
		queue_cmd(amge_pkg::OP_ADD, 5, 7);
		queue_cmd(amge_pkg::OP_COMMON, 0, 31);
		queue_cmd(amge_pkg::OP_COMMON, 5, 5);     // self loop counts as own neighbor
		queue_cmd(amge_pkg::OP_NOP, 31, 31);
		queue_cmd(amge_pkg::OP_WALK, 0, 31);

		// single vertex: anything above 0 rejected
		set_vertex_count(6'd1);
		queue_cmd(amge_pkg::OP_ADD, 0, 0);
		queue_cmd(amge_pkg::OP_COMMON, 0, 0);
		queue_cmd(amge_pkg::OP_WALK, 0, 31);      // second vertex ignored by walk
		queue_cmd(amge_pkg::OP_ADD, 0, 1);
		queue_cmd(amge_pkg::OP_COMMON, 1, 0);
		queue_cmd(amge_pkg::OP_WALK, 1, 0);
		queue_cmd(amge_pkg::OP_NOP, 1, 1);

		// zero count: every vertex invalid
		set_vertex_count(6'd0);
		queue_cmd(amge_pkg::OP_ADD, 0, 0);
		queue_cmd(amge_pkg::OP_COMMON, 0, 0);
		queue_cmd(amge_pkg::OP_WALK, 0, 0);

		// count above the matrix size clamps to 32
		set_vertex_count(6'd63);
		queue_cmd(amge_pkg::OP_WALK, 7, 0);
		queue_cmd(amge_pkg::OP_COMMON, 31, 0);
		queue_cmd(amge_pkg::OP_ADD, 31, 31);

		// random phases over several counts; the graph carries across phases
		counts[0] = 6'd32;
		counts[1] = 6'd2;
		counts[2] = amge_pkg::COUNT_W'($urandom_range(3, 16));
		counts[3] = amge_pkg::COUNT_W'($urandom_range(17, 31));
		counts[4] = 6'd32;
		for (p = 0; p < 5; p++) begin
			set_vertex_count(counts[p]);
			n = (counts[p] < NV) ? counts[p] : NV;
			for (j = 0; j < 21; j++)
				cmd_q = {cmd_q, random_cmd(n)};
		end

		settle();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
